/* rtl/bresenham_line_stepper_defines.svh */
// assertion macros shared by the line stepper checker
`ifndef BRESENHAM_LINE_STEPPER_DEFINES_SVH
`define BRESENHAM_LINE_STEPPER_DEFINES_SVH

// clocked check, masked while reset is held
`define BLT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("line stepper check failed");

// clocked check that also runs through reset
`define BLT_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("line stepper reset check failed");

`endif

/* rtl/blt_pkg.sv */
// shared types and constants for the bresenham line stepper
package blt_pkg;

  localparam int COORD_BITS    = 11;
  localparam int DTERM_BITS    = COORD_BITS + 3;
  localparam int LEFT_BITS     = COORD_BITS + 1;
  localparam int IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [DTERM_BITS-1:0] dterm_t;
  typedef logic [LEFT_BITS-1:0] left_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t opcode;
    coord_t  start_x;
    coord_t  start_y;
    coord_t  end_x;
    coord_t  end_y;
  } line_cmd_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   pixel_valid;
    logic   last_pixel;
  } pixel_t;

  // handshake between the input register and the result register
  typedef struct packed {
    logic vld;
    logic take;
  } stage_ctl_t;

endpackage

/* rtl/blt_in_stage.sv */
// input register: unpacks and holds one command word
module blt_in_stage import blt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_DATA_BITS-1:0] in_tdata,
  input  logic [0:0]              in_tuser,
  input  logic                    take,
  output logic                    vld,
  output line_cmd_t               cmd
);

  logic      vld_r;
  logic      vld_nxt;
  line_cmd_t cmd_r;
  line_cmd_t cmd_nxt;
  logic      load;

  assign in_tready = !vld_r || take;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    cmd_nxt.opcode  = opcode_t'(in_tuser[0]);
    cmd_nxt.start_x = in_tdata[COORD_BITS-1:0];
    cmd_nxt.start_y = in_tdata[2*COORD_BITS-1:COORD_BITS];
    cmd_nxt.end_x   = in_tdata[3*COORD_BITS-1:2*COORD_BITS];
    cmd_nxt.end_y   = in_tdata[4*COORD_BITS-1:3*COORD_BITS];
    vld_nxt = load || (vld_r && !take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign vld = vld_r;
  assign cmd = cmd_r;

endmodule

/* rtl/blt_step_core.sv */
// line state registers and the setup / next pixel logic
module blt_step_core import blt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  line_cmd_t cmd,
  output pixel_t    pix
);

  coord_t cur_x_r, cur_x_nxt;
  coord_t cur_y_r, cur_y_nxt;
  dterm_t dterm_r, dterm_nxt;
  left_t  left_r, left_nxt;
  coord_t dmaj_r, dmaj_nxt;
  coord_t dmin_r, dmin_nxt;
  logic   x_dn_r, x_dn_nxt;
  logic   y_dn_r, y_dn_nxt;
  logic   x_maj_r, x_maj_nxt;
  logic   active_r, active_nxt;

  coord_t dx;
  coord_t dy;
  logic   sx_dn;
  logic   sy_dn;
  logic   sx_maj;
  logic   diag;
  logic   move_x;
  logic   move_y;
  dterm_t two_min;
  dterm_t two_maj;

  always_comb begin
    // setup terms
    sx_dn  = cmd.end_x < cmd.start_x;
    sy_dn  = cmd.end_y < cmd.start_y;
    dx     = sx_dn ? (cmd.start_x - cmd.end_x) : (cmd.end_x - cmd.start_x);
    dy     = sy_dn ? (cmd.start_y - cmd.end_y) : (cmd.end_y - cmd.start_y);
    sx_maj = dx > dy;

    // stepping terms
    diag    = !dterm_r[DTERM_BITS-1];
    move_x  = x_maj_r || diag;
    move_y  = !x_maj_r || diag;
    two_min = dterm_t'({2'b00, dmin_r, 1'b0});
    two_maj = dterm_t'({2'b00, dmaj_r, 1'b0});

    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    dterm_nxt  = dterm_r;
    left_nxt   = left_r;
    dmaj_nxt   = dmaj_r;
    dmin_nxt   = dmin_r;
    x_dn_nxt   = x_dn_r;
    y_dn_nxt   = y_dn_r;
    x_maj_nxt  = x_maj_r;
    active_nxt = active_r;
    pix        = '0;

    if (cmd.opcode == OP_START) begin
      x_dn_nxt   = sx_dn;
      y_dn_nxt   = sy_dn;
      x_maj_nxt  = sx_maj;
      dmaj_nxt   = sx_maj ? dx : dy;
      dmin_nxt   = sx_maj ? dy : dx;
      dterm_nxt  = dterm_t'({2'b00, dmin_nxt, 1'b0}) - dterm_t'({3'b000, dmaj_nxt});
      left_nxt   = left_t'({1'b0, dmaj_nxt});
      cur_x_nxt  = cmd.start_x;
      cur_y_nxt  = cmd.start_y;
      active_nxt = dmaj_nxt != '0;
      pix.pixel_x     = cur_x_nxt;
      pix.pixel_y     = cur_y_nxt;
      pix.pixel_valid = 1'b1;
      pix.last_pixel  = !active_nxt;
    end else if (active_r) begin
      if (move_x) begin
        cur_x_nxt = x_dn_r ? (cur_x_r - coord_t'(1)) : (cur_x_r + coord_t'(1));
      end
      if (move_y) begin
        cur_y_nxt = y_dn_r ? (cur_y_r - coord_t'(1)) : (cur_y_r + coord_t'(1));
      end
      dterm_nxt  = dterm_r + two_min - (diag ? two_maj : dterm_t'(0));
      left_nxt   = left_r - left_t'(1);
      active_nxt = left_nxt != '0;
      pix.pixel_x     = cur_x_nxt;
      pix.pixel_y     = cur_y_nxt;
      pix.pixel_valid = 1'b1;
      pix.last_pixel  = !active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      dterm_r  <= '0;
      left_r   <= '0;
      dmaj_r   <= '0;
      dmin_r   <= '0;
      x_dn_r   <= 1'b0;
      y_dn_r   <= 1'b0;
      x_maj_r  <= 1'b0;
      active_r <= 1'b0;
    end else if (fire) begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      dterm_r  <= dterm_nxt;
      left_r   <= left_nxt;
      dmaj_r   <= dmaj_nxt;
      dmin_r   <= dmin_nxt;
      x_dn_r   <= x_dn_nxt;
      y_dn_r   <= y_dn_nxt;
      x_maj_r  <= x_maj_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

/* rtl/blt_out_stage.sv */
// result register: holds one pixel word until the sink takes it
module blt_out_stage import blt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  stage_ctl_t               ctl,
  output logic                     space,
  input  pixel_t                   pix,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  output logic [0:0]               out_tuser,
  output logic                     out_tlast
);

  logic   vld_r;
  logic   vld_nxt;
  pixel_t pix_r;

  assign space = !vld_r || out_tready;

  always_comb begin
    vld_nxt = ctl.take || (vld_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      pix_r <= pix;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = OUT_DATA_BITS'({pix_r.pixel_y, pix_r.pixel_x});
  assign out_tuser  = pix_r.pixel_valid;
  assign out_tlast  = pix_r.last_pixel;

endmodule

/* rtl/bresenham_line_stepper.sv */
// bresenham line stepper top level: input register, step core, result register
// order: input register, then result register, from an input word to its pixel word
// throughput: one word per cycle unless the sink stalls; the line state updates in
//   the same cycle that a word moves from the input register into the result register
// reset: synchronous active-low rst_n empties both registers and clears the line
//   state, so no line is active and a step word returns an invalid pixel
module bresenham_line_stepper import blt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // command channel
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // start_x, start_y, end_x, end_y, zero pad
  input  logic [0:0]               in_tuser,   // opcode (0 start, 1 step)
  // pixel channel
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // pixel_x, pixel_y, zero pad
  output logic [0:0]               out_tuser,  // pixel_valid
  output logic                     out_tlast   // last_pixel
);

  line_cmd_t  cmd;
  pixel_t     pix;
  stage_ctl_t ctl;
  logic       space;

  // a held command word advances whenever the result register is free or
  // being drained this cycle, so the core runs once per word
  assign ctl.take = ctl.vld && space;

  blt_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .take      (ctl.take),
    .vld       (ctl.vld),
    .cmd       (cmd)
  );

  // deltas, directions, decision term and current position live here
  blt_step_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (ctl.take),
    .cmd   (cmd),
    .pix   (pix)
  );

  // output register holds a pixel word until the sink takes it
  blt_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .space      (space),
    .pix        (pix),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* rtl/blt_checker.sv */
// port-level checks for the bresenham line stepper, bound to the top level
`include "bresenham_line_stepper_defines.svh"

module blt_checker import blt_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_tready,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [OUT_DATA_BITS-1:0] out_tdata,
  input logic [0:0]               out_tuser,
  input logic                     out_tlast
);

  // everything the sink sees in one pixel word
  logic [OUT_DATA_BITS+1:0] out_word;

  assign out_word = {out_tlast, out_tuser, out_tdata};

  // a stalled pixel word holds
  `BLT_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_word))

  // an invalid pixel carries zero coordinates
  `BLT_ASSERT(a_invalid_zero, out_tvalid && !out_tuser[0] |-> out_tdata == '0)

  // only a real pixel can end a line
  `BLT_ASSERT(a_last_valid, out_tvalid && out_tlast |-> out_tuser[0])

  // nothing is presented right after reset
  `BLT_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid)

  // the empty input register takes a word right after reset
  `BLT_ASSERT_RST(a_reset_ready, !rst_n |=> in_tready)

endmodule

bind bresenham_line_stepper blt_checker u_blt_checker (.*);

/* verif/bresenham_line_checker.sv */
// pixel predictor and scoreboard for the bresenham line stepper
module bresenham_line_checker import blt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  input  logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // start_x, start_y, end_x, end_y, zero pad
  input  logic [0:0]               in_tuser,   // opcode
  input  logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic [OUT_DATA_BITS-1:0] out_tdata,  // pixel_x, pixel_y, zero pad
  input  logic [0:0]               out_tuser,  // pixel_valid
  input  logic                     out_tlast,  // last_pixel
  output int                       fail_count,
  output int                       pending,
  output int                       compared
);

  // predicted line state
  coord_t pos_x, pos_y;
  int     err_term;
  left_t  steps_left;
  coord_t major_len, minor_len;
  logic   x_down, y_down, x_major, drawing;

  pixel_t pixel_q[$];
  int     errs = 0;
  int     seen = 0;

  function automatic coord_t step_coord(coord_t c, logic down);
    return down ? c - 1'b1 : c + 1'b1;
  endfunction

  // advances the predicted line by one command word, returns the pixel it yields
  function automatic pixel_t next_pixel(line_cmd_t cmd);
    coord_t dx, dy;
    logic   diag;
    pixel_t px;
    px = '0;
    if (cmd.opcode == OP_START) begin
      x_down    = cmd.end_x < cmd.start_x;
      y_down    = cmd.end_y < cmd.start_y;
      dx        = x_down ? cmd.start_x - cmd.end_x : cmd.end_x - cmd.start_x;
      dy        = y_down ? cmd.start_y - cmd.end_y : cmd.end_y - cmd.start_y;
      x_major   = dx > dy;
      major_len = x_major ? dx : dy;
      minor_len = x_major ? dy : dx;
      err_term  = 2 * int'(minor_len) - int'(major_len);
      steps_left = left_t'(major_len);
      pos_x     = cmd.start_x;
      pos_y     = cmd.start_y;
      drawing   = steps_left != 0;
      px = '{pixel_x: pos_x, pixel_y: pos_y, pixel_valid: 1'b1, last_pixel: !drawing};
    end else if (drawing) begin
      diag = err_term >= 0;
      if (x_major || diag) pos_x = step_coord(pos_x, x_down);
      if (!x_major || diag) pos_y = step_coord(pos_y, y_down);
      err_term = err_term + 2 * int'(minor_len);
      if (diag) err_term = err_term - 2 * int'(major_len);
      steps_left = steps_left - 1'b1;
      drawing    = steps_left != 0;
      px = '{pixel_x: pos_x, pixel_y: pos_y, pixel_valid: 1'b1, last_pixel: !drawing};
    end
    return px;
  endfunction

  always @(posedge clk) begin
    line_cmd_t cmd;
    pixel_t    want, got;
    if (!rst_n) begin
      pos_x = '0;
      pos_y = '0;
      err_term = 0;
      steps_left = '0;
      major_len = '0;
      minor_len = '0;
      x_down = 1'b0;
      y_down = 1'b0;
      x_major = 1'b0;
      drawing = 1'b0;
      pixel_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        cmd.opcode  = opcode_t'(in_tuser[0]);
        cmd.start_x = in_tdata[0*COORD_BITS +: COORD_BITS];
        cmd.start_y = in_tdata[1*COORD_BITS +: COORD_BITS];
        cmd.end_x   = in_tdata[2*COORD_BITS +: COORD_BITS];
        cmd.end_y   = in_tdata[3*COORD_BITS +: COORD_BITS];
        pixel_q.push_back(next_pixel(cmd));
      end
      if (out_tvalid && out_tready) begin
        got.pixel_x     = out_tdata[0 +: COORD_BITS];
        got.pixel_y     = out_tdata[COORD_BITS +: COORD_BITS];
        got.pixel_valid = out_tuser[0];
        got.last_pixel  = out_tlast;
        if (pixel_q.size() == 0) begin
          errs = errs + 1;
          $display("%0t: unexpected pixel word x=%0d y=%0d valid=%b last=%b", $time,
                   got.pixel_x, got.pixel_y, got.pixel_valid, got.last_pixel);
        end else begin
          want = pixel_q.pop_front();
          seen = seen + 1;
          if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
              got.pixel_valid !== want.pixel_valid || got.last_pixel !== want.last_pixel) begin
            errs = errs + 1;
            $display("%0t: pixel mismatch, expected x=%0d y=%0d valid=%b last=%b, got x=%0d y=%0d valid=%b last=%b",
                     $time, want.pixel_x, want.pixel_y, want.pixel_valid, want.last_pixel,
                     got.pixel_x, got.pixel_y, got.pixel_valid, got.last_pixel);
          end
        end
      end
    end
    fail_count <= errs;
    pending    <= pixel_q.size();
    compared   <= seen;
  end

endmodule

/* verif/tb_bresenham_line_stepper.sv */
// stimulus and verdict for the bresenham line stepper, checked by a separate scoreboard
module tb_bresenham_line_stepper;
  import blt_pkg::*;

  localparam int ITEM_TARGET  = 950;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 150;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata   = '0;
  logic [0:0]               in_tuser   = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic [0:0]               out_tuser;
  logic                     out_tlast;

  int fail_count, pending, compared;
  int cycles      = 0;
  int stall_left  = 0;
  int starts_sent = 0;
  int steps_sent  = 0;
  bit in_gaps_on    = 1'b0;
  bit out_stalls_on = 1'b0;

  bresenham_line_stepper dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  bresenham_line_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending),
    .compared   (compared)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d pixel words outstanding", cycles, pending);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver back-pressure if enabled: mostly ready, short stalls, now and then a long one
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!out_stalls_on || r < 75) begin
      out_tready <= 1'b1;
    end else if (r < 96) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(8, 40);
    end
  end

  // one command word, after an optional idle gap; returns at the accepting edge
  task automatic send_word(opcode_t op, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    int gap, r;
    gap = 0;
    r = $urandom_range(0, 99);
    if (in_gaps_on) begin
      if (r >= 96) gap = $urandom_range(6, 30);
      else if (r >= 65) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_DATA_BITS'({ey, ex, sy, sx});
    do @(posedge clk); while (!in_tready);
    if (op == OP_START) starts_sent++;
    else steps_sent++;
  endtask

  // step words carry random payload, the block must ignore it
  task automatic send_step();
    send_word(OP_STEP, coord_t'($urandom_range(0, 2047)), coord_t'($urandom_range(0, 2047)),
              coord_t'($urandom_range(0, 2047)), coord_t'($urandom_range(0, 2047)));
  endtask

  // hold the sender until the scoreboard has every pixel word back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // endpoint within span of c, clipped to the coordinate range
  function automatic coord_t coord_near(coord_t c, int span);
    int t;
    t = int'($urandom_range(0, 2 * span)) - span + int'(c);
    if (t < 0) t = 0;
    if (t > 2047) t = 2047;
    return coord_t'(t);
  endfunction

  // a random line: mostly short and walked to its end, sometimes cut short,
  // sometimes overrun so that steps land with no line active
  task automatic draw_line();
    coord_t sx, sy, ex, ey;
    int     r, dx, dy, major, n_steps;
    r  = $urandom_range(0, 99);
    sx = coord_t'($urandom_range(0, 2047));
    sy = coord_t'($urandom_range(0, 2047));
    if (r < 8) begin
      ex = coord_t'($urandom_range(0, 2047));
      ey = coord_t'($urandom_range(0, 2047));
    end else if (r < 85) begin
      ex = coord_near(sx, 12);
      ey = coord_near(sy, 12);
    end else begin
      ex = coord_near(sx, 60);
      ey = coord_near(sy, 60);
    end
    // occasional equal deltas for true diagonals
    if ($urandom_range(0, 9) == 0) ey = coord_near(sy, 0) + (ey > sy ? 1'b0 : 1'b0) +
                                       ((ex > sx) ? ex - sx : sx - ex);
    dx = (ex > sx) ? int'(ex - sx) : int'(sx - ex);
    dy = (ey > sy) ? int'(ey - sy) : int'(sy - ey);
    major = (dx > dy) ? dx : dy;
    r = $urandom_range(0, 99);
    if (major > 80) n_steps = $urandom_range(0, 12);
    else if (r < 70) n_steps = major;
    else if (r < 85) n_steps = $urandom_range(0, major);
    else n_steps = major + $urandom_range(1, 3);
    send_word(OP_START, sx, sy, ex, ey);
    repeat (n_steps) send_step();
  endtask

  initial begin
    int phase;
    phase = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words, no idling on either side
    send_step();                                       // no line yet: invalid pixel
    send_word(OP_START, 11'd0, 11'd0, 11'd0, 11'd0);   // single pixel line
    send_step();                                       // still nothing active
    send_word(OP_START, 11'd0, 11'd2047, 11'd2047, 11'd0);
    repeat (2) send_step();
    send_word(OP_START, 11'd2047, 11'd2047, 11'd0, 11'd0); // restart over an active line
    send_step();
    send_word(OP_START, 11'd10, 11'd10, 11'd14, 11'd8);  // shallow, x major, y falling
    repeat (5) send_step();                             // last one overruns the end
    send_word(OP_START, 11'd100, 11'd50, 11'd98, 11'd54); // steep, x falling
    repeat (4) send_step();
    send_word(OP_START, 11'd5, 11'd9, 11'd8, 11'd6);     // equal deltas, y major diagonal
    repeat (3) send_step();
    send_word(OP_START, 11'd2047, 11'd0, 11'd2047, 11'd0);
    drain();

    // random lines; each phase picks its own idling mix and starts from an empty pipe
    while (starts_sent + steps_sent < ITEM_TARGET) begin
      if ((starts_sent + steps_sent) / PHASE_ITEMS != phase) begin
        phase = (starts_sent + steps_sent) / PHASE_ITEMS;
        drain();
        in_gaps_on    <= ($urandom_range(0, 3) != 0);
        out_stalls_on <= ($urandom_range(0, 3) != 0);
      end
      draw_line();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d line starts and %0d step words, all octants, with idle gaps",
             starts_sent, steps_sent);
    $display("and receiver stalls; %0d pixel words compared", compared);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
